FILE: design/mwpo_pkg.sv
// ----------------------------------------------------------------------------
// mwpo_pkg
// Shared types, register indexes and constants of the phase oscillator, and
// the function that builds the quarter-wave sine table at elaboration.
// ----------------------------------------------------------------------------
package mwpo_pkg;

   typedef enum logic [1:0] {
      WAVE_SINE   = 2'd0,
      WAVE_SAW    = 2'd1,
      WAVE_SQUARE = 2'd2,
      WAVE_NOISE  = 2'd3
   } waveform_type;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;
   localparam int INCREMENT_BITS = 32;
   localparam int LFSR_BITS      = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WAVEFORM        = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_INCREMENT = 1'd1;

   localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 32'h8020_0003;
   localparam logic [LFSR_BITS-1:0] LFSR_SEED = 32'hACE1_ACE1;

   // pi/2 in Q2.30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // rounded-up reciprocals of the Taylor divisors (2n)(2n+1); multiply and
   // shift gives the exact floor quotient for dividends below 2^34
   localparam int              RECIP_SHIFT = 42;
   localparam longint unsigned RECIP_6     = ((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6;
   localparam longint unsigned RECIP_20    = ((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20;
   localparam longint unsigned RECIP_42    = ((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42;
   localparam longint unsigned RECIP_72    = ((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72;
   localparam longint unsigned RECIP_110   = ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110;
   localparam longint unsigned RECIP_156   = ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156;
   localparam longint unsigned RECIP_210   = ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210;

   // one table entry: round(full_scale * sin(pi/2 * k / 2^quarter_log2)),
   // sine by Taylor series in Q2.30, clamped to 0..full_scale
   function automatic longint unsigned sine_entry(input int unsigned k,
                                                  input int unsigned quarter_log2,
                                                  input longint unsigned full_scale);
      longint unsigned x;
      longint unsigned term;
      longint unsigned recip;
      longint unsigned rounded;
      logic [127:0]    wide;
      longint          sum;
      x = (HALF_PI_Q30 * 64'(k)) >> quarter_log2;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         case (n)
            1:       recip = RECIP_6;
            2:       recip = RECIP_20;
            3:       recip = RECIP_42;
            4:       recip = RECIP_72;
            5:       recip = RECIP_110;
            6:       recip = RECIP_156;
            default: recip = RECIP_210;
         endcase
         wide = 128'(term) * 128'(recip);
         term = 64'(wide >> RECIP_SHIFT);
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      rounded = (longint'(sum) * full_scale + (64'd1 << 29)) >> 30;
      if (rounded > full_scale) begin
         rounded = full_scale;
      end
      return rounded;
   endfunction

endpackage

FILE: design/mwpo_req_if.sv
// ----------------------------------------------------------------------------
// mwpo_req_if
// Request channel of the phase oscillator: one tick per sample wanted.
// ----------------------------------------------------------------------------
interface mwpo_req_if;

   logic valid;
   logic ready;
   logic restart_phase;

   modport source (output valid, output restart_phase, input ready);
   modport sink (input valid, input restart_phase, output ready);

endinterface

FILE: design/mwpo_rsp_if.sv
// ----------------------------------------------------------------------------
// mwpo_rsp_if
// Response channel of the phase oscillator: one signed sample per transfer.
// ----------------------------------------------------------------------------
interface mwpo_rsp_if #(
   parameter int SAMPLE_BITS = 16
);

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);

endinterface

FILE: design/multi_waveform_phase_oscillator_core.sv
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator_core
// Numerically controlled oscillator with sine, sawtooth, square and noise
// outputs in signed Q1.(SAMPLE_BITS-1).
// ----------------------------------------------------------------------------
// Each request transfer yields one sample: a new request is taken every cycle while
// the response side is not stalled. The first stage forms the phase, the table
// index and the direct waveforms and steps the phase accumulator; the response
// stage reads the sine table and applies the sign. The sine table holds one
// quarter wave of 2^(SINE_TABLE_BITS-2)+1 entries and is built at elaboration, so
// no fill pass follows reset. The response side is a register stage; requests keep
// flowing while a sample waits, until both stages hold data. The phase accumulator
// and the noise LFSR advance only on request transfers; the LFSR steps only while
// noise is selected. Registers must be written only while idle; the block does not check.
// ----------------------------------------------------------------------------
module multi_waveform_phase_oscillator_core #(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mwpo_req_if.sink                             req_ch,
   mwpo_rsp_if.source                           rsp_ch,
   input  logic                                 csr_write_en,
   input  logic [mwpo_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mwpo_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   import mwpo_pkg::*;

   localparam int QUARTER_LOG2  = SINE_TABLE_BITS - 2;
   localparam int QUARTER_STEPS = 1 << QUARTER_LOG2;
   localparam int INDEX_BITS    = SINE_TABLE_BITS - 1;

   localparam longint unsigned FULL_SCALE_VALUE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

   localparam logic signed [SAMPLE_BITS-1:0] FULL_SCALE =
      {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] NEG_FULL_SCALE =
      {1'b1, {(SAMPLE_BITS-2){1'b0}}, 1'b1};
   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // configuration
   waveform_type                waveform_ff;
   logic [INCREMENT_BITS-1:0]   phase_increment_ff;

   // oscillator state
   logic [PHASE_BITS-1:0]       phase_ff;
   logic [PHASE_BITS-1:0]       phase_in;
   logic [LFSR_BITS-1:0]        lfsr_ff;
   logic [LFSR_BITS-1:0]        lfsr_in;

   // first stage
   logic                          s1_valid_ff;
   logic                          s1_is_sine_ff;
   logic                          s1_negate_ff;
   logic [INDEX_BITS-1:0]         s1_index_ff;
   logic [INDEX_BITS-1:0]         s1_index_in;
   logic signed [SAMPLE_BITS-1:0] s1_direct_ff;
   logic signed [SAMPLE_BITS-1:0] s1_direct_in;

   // response stage
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   logic                          accept;
   logic                          s2_enable;
   logic [PHASE_BITS-1:0]         cur_phase;
   logic [PHASE_BITS-1:0]         phase_step;
   logic [1:0]                    quadrant;
   logic [QUARTER_LOG2-1:0]       table_pos;
   logic [SAMPLE_BITS-1:0]        saw_top;
   logic signed [SAMPLE_BITS-1:0] saw_value;
   logic signed [SAMPLE_BITS-1:0] square_value;
   logic signed [SAMPLE_BITS-1:0] noise_top;
   logic signed [SAMPLE_BITS-1:0] noise_value;
   logic signed [SAMPLE_BITS-1:0] sine_value;

   logic [SAMPLE_BITS-2:0]        sine_rom [QUARTER_STEPS+1];

   // quarter-wave table, constant after elaboration
   for (genvar k = 0; k <= QUARTER_STEPS; k++) begin : g_sine_rom
      assign sine_rom[k] = (SAMPLE_BITS-1)'(sine_entry(k, QUARTER_LOG2, FULL_SCALE_VALUE));
   end

   // increment scaled to the accumulator width
   if (PHASE_BITS >= INCREMENT_BITS) begin : g_step_wide
      assign phase_step = PHASE_BITS'(phase_increment_ff) << (PHASE_BITS - INCREMENT_BITS);
   end else begin : g_step_narrow
      assign phase_step = PHASE_BITS'(phase_increment_ff >> (INCREMENT_BITS - PHASE_BITS));
   end

   if (PHASE_BITS >= SAMPLE_BITS) begin : g_saw_wide
      assign saw_top = cur_phase[PHASE_BITS-1 -: SAMPLE_BITS];
   end else begin : g_saw_narrow
      assign saw_top = {cur_phase, {(SAMPLE_BITS-PHASE_BITS){1'b0}}};
   end

   assign s2_enable     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = !s1_valid_ff || s2_enable;
   assign accept        = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample = sample_ff;

   always_comb begin
      cur_phase = req_ch.restart_phase ? '0 : phase_ff;
      phase_in  = cur_phase + phase_step;

      quadrant  = cur_phase[PHASE_BITS-1 -: 2];
      table_pos = cur_phase[PHASE_BITS-3 -: QUARTER_LOG2];
      if (quadrant[0]) begin
         s1_index_in = INDEX_BITS'(QUARTER_STEPS) - {1'b0, table_pos};
      end else begin
         s1_index_in = {1'b0, table_pos};
      end

      // top bits minus one half is the top bits with the sign bit flipped
      if (saw_top == '0) begin
         saw_value = NEG_FULL_SCALE;
      end else begin
         saw_value = {~saw_top[SAMPLE_BITS-1], saw_top[SAMPLE_BITS-2:0]};
      end

      square_value = cur_phase[PHASE_BITS-1] ? FULL_SCALE : NEG_FULL_SCALE;

      lfsr_in   = {1'b0, lfsr_ff[LFSR_BITS-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
      noise_top = lfsr_in[LFSR_BITS-1 -: SAMPLE_BITS];
      noise_value = (noise_top == MOST_NEG) ? NEG_FULL_SCALE : noise_top;

      case (waveform_ff)
         WAVE_SINE:   s1_direct_in = '0;
         WAVE_SAW:    s1_direct_in = saw_value;
         WAVE_SQUARE: s1_direct_in = square_value;
         WAVE_NOISE:  s1_direct_in = noise_value;
      endcase

      sine_value = $signed({1'b0, sine_rom[s1_index_ff]});
      if (!s1_is_sine_ff) begin
         sample_in = s1_direct_ff;
      end else if (s1_negate_ff) begin
         sample_in = -sine_value;
      end else begin
         sample_in = sine_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff        <= WAVE_NOISE;
         phase_increment_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_WAVEFORM:        waveform_ff <= waveform_type'(csr_write_data[1:0]);
            REG_PHASE_INCREMENT: phase_increment_ff <= csr_write_data[INCREMENT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         lfsr_ff  <= LFSR_SEED;
      end else if (accept) begin
         phase_ff <= phase_in;
         if (waveform_ff == WAVE_NOISE) begin
            lfsr_ff <= lfsr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s2_enable) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_is_sine_ff <= (waveform_ff == WAVE_SINE);
         s1_negate_ff  <= quadrant[1];
         s1_index_ff   <= s1_index_in;
         s1_direct_ff  <= s1_direct_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_enable) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s2_enable) begin
         sample_ff <= sample_in;
      end
   end

`ifndef ASSERT_OFF
   // a maximal-length lfsr never reaches the all-zero lockup state
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("noise lfsr reached zero");

   // the lfsr steps only on a noise transfer
   a_lfsr_holds: assert property (@(posedge clock) disable iff (reset)
      !(accept && waveform_ff == WAVE_NOISE) |=> $stable(lfsr_ff))
      else $error("noise lfsr moved without a noise transfer");

   // a restart leaves exactly one step in the accumulator
   a_restart_phase: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.restart_phase |=> phase_ff == $past(phase_step))
      else $error("restart did not clear the phase");

   // both stages full and the output stalled: no new request may enter
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken with a full pipeline");

   // the most negative code is never produced
   a_no_most_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> sample_ff != MOST_NEG)
      else $error("sample holds the most negative code");
`endif

endmodule
